FILE: rtl/ftcg_pkg.sv
// Shared types, widths and helpers for the floor texture coordinate generator.
// Used by every module of the block; depends on nothing.
package ftcg_pkg;

    localparam int ROW_W     = 11;                  // row and column fields
    localparam int TEXEL_W   = 12;                  // texel address field
    localparam int CFG_W     = 32;                  // Q16.16 camera registers
    localparam int SCR_W     = 12;                  // screen size registers
    localparam int FRAC_W    = 16;                  // fraction bits of Q16.16
    localparam int MAX_RES   = 2048;                // screen size clamp
    localparam int RD_W      = SCR_W + FRAC_W - 1;  // row distance, H*32768/p
    localparam int MAG_W     = CFG_W + 1;           // magnitude of dir - plane
    localparam int PROD_W    = MAG_W + RD_W;        // operand times row distance
    localparam int DVD_W     = PROD_W - FRAC_W + 1; // step dividend, 2*a*rd/65536
    localparam int DVS_W     = SCR_W;               // divisor width
    localparam int SUM_W     = DVD_W + 1;           // signed wide result before clamp
    localparam int CNT_W     = $clog2(DVD_W + 1);   // divider step counter
    localparam int Q_DEPTH   = 2;                   // front to back queue
    localparam int Q_AW      = 1;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_W-1:0] SAT_MAX = {1'b0, {(CFG_W-1){1'b1}}};
    localparam logic [CFG_W-1:0] SAT_MIN = {1'b1, {(CFG_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POS_X         = 3'd0,
        REG_POS_Y         = 3'd1,
        REG_DIR_X         = 3'd2,
        REG_DIR_Y         = 3'd3,
        REG_PLANE_X       = 3'd4,
        REG_PLANE_Y       = 3'd5,
        REG_SCREEN_WIDTH  = 3'd6,
        REG_SCREEN_HEIGHT = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] pos_x;
        logic [CFG_W-1:0] pos_y;
        logic [CFG_W-1:0] dir_x;
        logic [CFG_W-1:0] dir_y;
        logic [CFG_W-1:0] plane_x;
        logic [CFG_W-1:0] plane_y;
    } cam_cfg_t;

    // One classified pixel on its way from the front to the back.
    typedef struct packed {
        logic             ok;        // row strictly inside the lower half
        logic             start;     // column zero: new row
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] column;
        logic [ROW_W-1:0] ceil_row;  // zero when the row is out of range
        logic [ROW_W-1:0] row_off;   // row minus half height
    } ftcg_item_t;

    // Clamp a wide two's complement value to signed 32 bits.
    function automatic logic [CFG_W-1:0] sat_wide(input logic [SUM_W-1:0] v);
        logic [CFG_W-1:0] r;
        if ((~|v[SUM_W-1:CFG_W-1]) || (&v[SUM_W-1:CFG_W-1])) begin
            r = v[CFG_W-1:0];
        end else if (v[SUM_W-1]) begin
            r = SAT_MIN;
        end else begin
            r = SAT_MAX;
        end
        return r;
    endfunction

endpackage

FILE: rtl/floor_texture_coord_gen.sv
// Floor and ceiling texture coordinate generator, Q16.16 fixed point.
// Top level: configuration registers, front end, item queue, back end.
//
// Usage: write the camera (pos, dir, plane) and screen size registers through
// the cfg_wr_en / cfg_index / cfg_wdata port while the block is idle. Then
// stream pixels (s_row, s_column) on the s_ channel with valid/ready; each
// pixel gives exactly one item on the m_ channel, in order.
// A pixel with column zero in the lower half of the screen starts a new row:
// the back end computes the row distance and both steps on one shared
// bit-serial divider (three divisions) and the start position on one
// shared multiplier. Every other pixel passes the queue and the output
// register; one item per cycle is sustained while m_ready is high and no
// row setup is running.
// A two-entry queue separates the front end from the back end, and an output
// register holds a result while m_ready is low; the input stalls only when
// the queue is full.
// Reset (aresetn low, synchronous) clears the camera registers and the floor
// position and step to zero and sets the screen to 640 x 480.
module floor_texture_coord_gen #(
    parameter int TEX_SIZE = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ftcg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ftcg_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [ftcg_pkg::ROW_W-1:0]           s_row,
    input  logic [ftcg_pkg::ROW_W-1:0]           s_column,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [ftcg_pkg::TEXEL_W-1:0]         m_texel_index,
    output logic [ftcg_pkg::ROW_W-1:0]           m_floor_row,
    output logic [ftcg_pkg::ROW_W-1:0]           m_ceiling_row,
    output logic [ftcg_pkg::ROW_W-1:0]           m_pixel_column,
    output logic                                 m_row_ok
);

    ftcg_pkg::cam_cfg_t              cam_reg;
    logic [ftcg_pkg::SCR_W-1:0]      scr_width_reg;
    logic [ftcg_pkg::SCR_W-1:0]      scr_height_reg;

    logic [ftcg_pkg::SCR_W-1:0]      h_clamp;
    logic [ftcg_pkg::SCR_W-1:0]      w_clamp;
    logic [ftcg_pkg::SCR_W-1:0]      w_eff;

    logic                            q_full;
    logic                            q_push;
    ftcg_pkg::ftcg_item_t            q_in;
    logic                            q_pop;
    logic                            q_not_empty;
    ftcg_pkg::ftcg_item_t            q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_reg        <= '0;
            scr_width_reg  <= ftcg_pkg::SCR_W'(640);
            scr_height_reg <= ftcg_pkg::SCR_W'(480);
        end else if (cfg_wr_en) begin
            case (ftcg_pkg::cfg_reg_t'(cfg_index))
                ftcg_pkg::REG_POS_X:         cam_reg.pos_x   <= cfg_wdata;
                ftcg_pkg::REG_POS_Y:         cam_reg.pos_y   <= cfg_wdata;
                ftcg_pkg::REG_DIR_X:         cam_reg.dir_x   <= cfg_wdata;
                ftcg_pkg::REG_DIR_Y:         cam_reg.dir_y   <= cfg_wdata;
                ftcg_pkg::REG_PLANE_X:       cam_reg.plane_x <= cfg_wdata;
                ftcg_pkg::REG_PLANE_Y:       cam_reg.plane_y <= cfg_wdata;
                ftcg_pkg::REG_SCREEN_WIDTH:  scr_width_reg   <= cfg_wdata[ftcg_pkg::SCR_W-1:0];
                ftcg_pkg::REG_SCREEN_HEIGHT: scr_height_reg  <= cfg_wdata[ftcg_pkg::SCR_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp screen sizes; a zero width divides as one.
    assign h_clamp = ({1'b0, scr_height_reg} > (ftcg_pkg::SCR_W+1)'(ftcg_pkg::MAX_RES))
                   ? ftcg_pkg::SCR_W'(ftcg_pkg::MAX_RES) : scr_height_reg;
    assign w_clamp = ({1'b0, scr_width_reg} > (ftcg_pkg::SCR_W+1)'(ftcg_pkg::MAX_RES))
                   ? ftcg_pkg::SCR_W'(ftcg_pkg::MAX_RES) : scr_width_reg;
    assign w_eff   = (w_clamp == '0) ? ftcg_pkg::SCR_W'(1) : w_clamp;

    ftcg_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_row      (s_row),
        .s_column   (s_column),
        .scr_height (h_clamp),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_in)
    );

    ftcg_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    ftcg_back #(
        .TEX_SIZE (TEX_SIZE)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_not_empty),
        .q_item         (q_head),
        .q_pop          (q_pop),
        .cam            (cam_reg),
        .scr_height     (h_clamp),
        .scr_width      (w_eff),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_texel_index  (m_texel_index),
        .m_floor_row    (m_floor_row),
        .m_ceiling_row  (m_ceiling_row),
        .m_pixel_column (m_pixel_column),
        .m_row_ok       (m_row_ok)
    );

endmodule

FILE: rtl/ftcg_front.sv
// Front end: accepts pixels and classifies them (row range, row start, offsets).
// Depends on ftcg_pkg; feeds ftcg_fifo.
module ftcg_front (
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ftcg_pkg::ROW_W-1:0]       s_row,
    input  logic [ftcg_pkg::ROW_W-1:0]       s_column,
    input  logic [ftcg_pkg::SCR_W-1:0]       scr_height,
    input  logic                             q_full,
    output logic                             q_push,
    output ftcg_pkg::ftcg_item_t             q_item
);

    logic [ftcg_pkg::SCR_W-1:0] half;
    logic [ftcg_pkg::SCR_W-1:0] row_e;
    logic [ftcg_pkg::SCR_W-1:0] off_w;
    logic [ftcg_pkg::SCR_W-1:0] ceil_w;
    logic                       ok;

    assign half   = scr_height >> 1;
    assign row_e  = {1'b0, s_row};
    assign ok     = (row_e > half) && (row_e < scr_height);
    assign off_w  = row_e - half;
    assign ceil_w = scr_height - row_e - ftcg_pkg::SCR_W'(1);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_item.ok       = ok;
        q_item.start    = (s_column == '0);
        q_item.row      = s_row;
        q_item.column   = s_column;
        q_item.ceil_row = ok ? ceil_w[ftcg_pkg::ROW_W-1:0] : '0;
        q_item.row_off  = off_w[ftcg_pkg::ROW_W-1:0];
    end

endmodule

FILE: rtl/ftcg_fifo.sv
// Short item queue between the front end and the back end.
// Depends on ftcg_pkg for the item type and depth.
module ftcg_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ftcg_pkg::ftcg_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output ftcg_pkg::ftcg_item_t head
);

    ftcg_pkg::ftcg_item_t        mem_reg [ftcg_pkg::Q_DEPTH];
    logic [ftcg_pkg::Q_AW-1:0]   wptr_reg;
    logic [ftcg_pkg::Q_AW-1:0]   rptr_reg;
    logic [ftcg_pkg::Q_AW:0]     cnt_reg;

    assign full      = (cnt_reg == (ftcg_pkg::Q_AW+1)'(ftcg_pkg::Q_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + ftcg_pkg::Q_AW'(1);
            end
            if (pop) begin
                rptr_reg <= rptr_reg + ftcg_pkg::Q_AW'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + (ftcg_pkg::Q_AW+1)'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - (ftcg_pkg::Q_AW+1)'(1);
            end
        end
    end

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue popped while empty");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue pushed while full");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + (ftcg_pkg::Q_AW+1)'(1)))
        else $error("queue count did not advance on push");

endmodule

FILE: rtl/ftcg_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ftcg_pkg for the dividend and divisor widths.
module ftcg_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ftcg_pkg::DVD_W-1:0]   dividend,
    input  logic [ftcg_pkg::DVS_W-1:0]   divisor,
    output logic                         busy,
    output logic                         done,
    output logic [ftcg_pkg::DVD_W-1:0]   quotient
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [ftcg_pkg::CNT_W-1:0]   cnt_reg;
    logic [ftcg_pkg::DVD_W-1:0]   dvd_reg;
    logic [ftcg_pkg::DVS_W-1:0]   rem_reg;
    logic [ftcg_pkg::DVS_W-1:0]   dvs_reg;

    logic [ftcg_pkg::DVS_W:0]     trial;
    logic [ftcg_pkg::DVS_W:0]     diff;
    logic                         ge;

    assign trial = {rem_reg, dvd_reg[ftcg_pkg::DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dvd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == ftcg_pkg::CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ftcg_pkg::CNT_W'(ftcg_pkg::DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - ftcg_pkg::CNT_W'(1);
                if (cnt_reg == ftcg_pkg::CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Shift the dividend out at the top, the quotient bits in at the bottom.
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[ftcg_pkg::DVD_W-2:0], ge};
            rem_reg <= ge ? diff[ftcg_pkg::DVS_W-1:0] : trial[ftcg_pkg::DVS_W-1:0];
        end
    end

endmodule

FILE: rtl/ftcg_back.sv
// Back end: row setup sequencer (row distance, steps, start position), texel
// address and output register. Depends on ftcg_pkg and ftcg_div.
module ftcg_back #(
    parameter int TEX_SIZE = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  ftcg_pkg::ftcg_item_t             q_item,
    output logic                             q_pop,
    input  ftcg_pkg::cam_cfg_t               cam,
    input  logic [ftcg_pkg::SCR_W-1:0]       scr_height,
    input  logic [ftcg_pkg::SCR_W-1:0]       scr_width,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ftcg_pkg::TEXEL_W-1:0]     m_texel_index,
    output logic [ftcg_pkg::ROW_W-1:0]       m_floor_row,
    output logic [ftcg_pkg::ROW_W-1:0]       m_ceiling_row,
    output logic [ftcg_pkg::ROW_W-1:0]       m_pixel_column,
    output logic                             m_row_ok
);

    localparam int TEX_W = $clog2(TEX_SIZE);
    localparam logic [TEX_W-1:0] TEX_MASK = TEX_W'(TEX_SIZE - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_OPER,
        ST_MUL,
        ST_SCALE,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t                              state_reg;
    logic [1:0]                          k_reg;      // 0,1: steps x,y; 2,3: start x,y
    ftcg_pkg::ftcg_item_t                cur_reg;
    logic [ftcg_pkg::RD_W-1:0]           rd_reg;
    logic [ftcg_pkg::MAG_W-1:0]          mag_reg;
    logic                                neg_reg;
    logic [ftcg_pkg::PROD_W-1:0]         prod_reg;
    logic [ftcg_pkg::CFG_W-1:0]          fpos_x_reg;
    logic [ftcg_pkg::CFG_W-1:0]          fpos_y_reg;
    logic [ftcg_pkg::CFG_W-1:0]          step_x_reg;
    logic [ftcg_pkg::CFG_W-1:0]          step_y_reg;

    logic                                m_valid_reg;
    logic [ftcg_pkg::TEXEL_W-1:0]        m_texel_index_reg;
    logic [ftcg_pkg::ROW_W-1:0]          m_floor_row_reg;
    logic [ftcg_pkg::ROW_W-1:0]          m_ceiling_row_reg;
    logic [ftcg_pkg::ROW_W-1:0]          m_pixel_column_reg;
    logic                                m_row_ok_reg;

    logic                                out_free;
    logic                                head_rs;
    logic                                emit;
    ftcg_pkg::ftcg_item_t                emit_item;
    logic [TEX_W-1:0]                    tx;
    logic [TEX_W-1:0]                    ty;
    logic [ftcg_pkg::TEXEL_W-1:0]        texel;

    logic [ftcg_pkg::MAG_W-1:0]          oper_a;
    logic [ftcg_pkg::MAG_W-1:0]          oper_mag;
    logic                                oper_neg;

    logic [ftcg_pkg::SUM_W-1:0]          off_e;
    logic [ftcg_pkg::SUM_W-1:0]          off_s;
    logic [ftcg_pkg::SUM_W-1:0]          pos_e;
    logic [ftcg_pkg::CFG_W-1:0]          start_sat;
    logic [ftcg_pkg::SUM_W-1:0]          quo_e;
    logic [ftcg_pkg::CFG_W-1:0]          step_sat;

    logic                                div_start;
    logic [ftcg_pkg::DVD_W-1:0]          div_dvd;
    logic [ftcg_pkg::DVS_W-1:0]          div_dvs;
    logic                                div_busy;
    logic                                div_done;
    logic [ftcg_pkg::DVD_W-1:0]          div_quo;

    // Texture coordinate: fraction truncated toward zero, scaled, masked.
    function automatic logic [TEX_W-1:0] tex_coord(input logic [ftcg_pkg::CFG_W-1:0] v);
        logic [ftcg_pkg::FRAC_W-1:0]       fr;
        logic [ftcg_pkg::FRAC_W+TEX_W-1:0] sc;
        logic [TEX_W-1:0]                  tm;
        logic [TEX_W-1:0]                  t;
        fr = v[ftcg_pkg::CFG_W-1] ? (~v[ftcg_pkg::FRAC_W-1:0] + ftcg_pkg::FRAC_W'(1))
                                  : v[ftcg_pkg::FRAC_W-1:0];
        sc = (ftcg_pkg::FRAC_W+TEX_W)'(fr * TEX_SIZE);
        tm = sc[ftcg_pkg::FRAC_W +: TEX_W];
        t  = v[ftcg_pkg::CFG_W-1] ? (TEX_W'(0) - tm) : tm;
        return t & TEX_MASK;
    endfunction

    assign out_free  = !m_valid_reg || m_ready;
    assign head_rs   = q_item.ok && q_item.start;
    assign emit_item = (state_reg == ST_EMIT) ? cur_reg : q_item;
    assign emit      = ((state_reg == ST_IDLE) && q_valid && !head_rs && out_free)
                    || ((state_reg == ST_EMIT) && out_free);
    assign q_pop     = (state_reg == ST_IDLE) && q_valid && (head_rs || out_free);

    assign tx    = tex_coord(fpos_x_reg);
    assign ty    = tex_coord(fpos_y_reg);
    assign texel = ftcg_pkg::TEXEL_W'(ty * TEX_SIZE + tx);

    // Multiplier operand for the current setup step, in sign and magnitude.
    always_comb begin
        case (k_reg)
            2'd0: oper_a = {cam.plane_x[ftcg_pkg::CFG_W-1], cam.plane_x};
            2'd1: oper_a = {cam.plane_y[ftcg_pkg::CFG_W-1], cam.plane_y};
            2'd2: oper_a = {cam.dir_x[ftcg_pkg::CFG_W-1], cam.dir_x}
                         - {cam.plane_x[ftcg_pkg::CFG_W-1], cam.plane_x};
            2'd3: oper_a = {cam.dir_y[ftcg_pkg::CFG_W-1], cam.dir_y}
                         - {cam.plane_y[ftcg_pkg::CFG_W-1], cam.plane_y};
            default: oper_a = '0;
        endcase
        oper_neg = oper_a[ftcg_pkg::MAG_W-1];
        oper_mag = oper_neg ? (ftcg_pkg::MAG_W'(0) - oper_a) : oper_a;
    end

    // Start position: pos + trunc((dir - plane) * rd / 65536), clamped.
    always_comb begin
        off_e     = ftcg_pkg::SUM_W'(prod_reg[ftcg_pkg::PROD_W-1:ftcg_pkg::FRAC_W]);
        off_s     = neg_reg ? (ftcg_pkg::SUM_W'(0) - off_e) : off_e;
        pos_e     = k_reg[0]
                  ? {{(ftcg_pkg::SUM_W-ftcg_pkg::CFG_W){cam.pos_y[ftcg_pkg::CFG_W-1]}},
                     cam.pos_y}
                  : {{(ftcg_pkg::SUM_W-ftcg_pkg::CFG_W){cam.pos_x[ftcg_pkg::CFG_W-1]}},
                     cam.pos_x};
        start_sat = ftcg_pkg::sat_wide(pos_e + off_s);
        quo_e     = {1'b0, div_quo};
        step_sat  = ftcg_pkg::sat_wide(neg_reg ? (ftcg_pkg::SUM_W'(0) - quo_e) : quo_e);
    end

    // Divider serves the row distance first, then both per-pixel steps.
    always_comb begin
        div_start = ((state_reg == ST_IDLE) && q_valid && head_rs)
                 || ((state_reg == ST_SCALE) && !k_reg[1]);
        if (state_reg == ST_IDLE) begin
            div_dvd = ftcg_pkg::DVD_W'({scr_height, (ftcg_pkg::FRAC_W-1)'(0)});
            div_dvs = {1'b0, q_item.row_off};
        end else begin
            div_dvd = prod_reg[ftcg_pkg::PROD_W-1 -: ftcg_pkg::DVD_W];
            div_dvs = scr_width;
        end
    end

    ftcg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
            fpos_x_reg  <= '0;
            fpos_y_reg  <= '0;
            step_x_reg  <= '0;
            step_y_reg  <= '0;
        end else begin
            if (emit) begin
                m_valid_reg        <= 1'b1;
                m_texel_index_reg  <= emit_item.ok ? texel : '0;
                m_floor_row_reg    <= emit_item.row;
                m_ceiling_row_reg  <= emit_item.ceil_row;
                m_pixel_column_reg <= emit_item.column;
                m_row_ok_reg       <= emit_item.ok;
                // advance along the row only for pixels that are drawn
                if (emit_item.ok) begin
                    fpos_x_reg <= fpos_x_reg + step_x_reg;
                    fpos_y_reg <= fpos_y_reg + step_y_reg;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid && head_rs) begin
                        cur_reg   <= q_item;
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    if (div_done) begin
                        rd_reg    <= div_quo[ftcg_pkg::RD_W-1:0];
                        k_reg     <= '0;
                        state_reg <= ST_OPER;
                    end
                end
                ST_OPER: begin
                    mag_reg   <= oper_mag;
                    neg_reg   <= oper_neg;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= ftcg_pkg::PROD_W'(mag_reg) * ftcg_pkg::PROD_W'(rd_reg);
                    state_reg <= ST_SCALE;
                end
                ST_SCALE: begin
                    if (!k_reg[1]) begin
                        state_reg <= ST_DIV;
                    end else begin
                        if (k_reg[0]) begin
                            fpos_y_reg <= start_sat;
                            state_reg  <= ST_EMIT;
                        end else begin
                            fpos_x_reg <= start_sat;
                            state_reg  <= ST_OPER;
                        end
                        k_reg <= k_reg + 2'd1;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (k_reg[0]) begin
                            step_y_reg <= step_sat;
                        end else begin
                            step_x_reg <= step_sat;
                        end
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= ST_OPER;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_texel_index  = m_texel_index_reg;
    assign m_floor_row    = m_floor_row_reg;
    assign m_ceiling_row  = m_ceiling_row_reg;
    assign m_pixel_column = m_pixel_column_reg;
    assign m_row_ok       = m_row_ok_reg;

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_RD || state_reg == ST_DIV))
        else $error("divider result arrived outside a wait state");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("back end popped an empty queue");

    a_emit_rowstart: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (cur_reg.ok && cur_reg.start))
        else $error("row setup finished for an item that needs none");

endmodule

FILE: verif/floor_texture_coord_gen_tb.sv
// Self-checking testbench for floor_texture_coord_gen: drives pixels and camera
// settings, predicts every result item in a scoreboard class and checks it in order.
// Depends on rtl/ftcg_pkg.sv and rtl/floor_texture_coord_gen.sv.
module floor_texture_coord_gen_tb;

    localparam int TEX_SIZE   = 64;
    localparam int HANG_LIMIT = 4000;

    // One result item as the block presents it.
    typedef struct packed {
        logic [ftcg_pkg::TEXEL_W-1:0] texel;
        logic [ftcg_pkg::ROW_W-1:0]   floor_row;
        logic [ftcg_pkg::ROW_W-1:0]   ceiling_row;
        logic [ftcg_pkg::ROW_W-1:0]   column;
        logic                         ok;
    } floor_px_t;

    class floor_px_board;
        logic [ftcg_pkg::CFG_W-1:0] cam [0:5];
        logic [ftcg_pkg::SCR_W-1:0] scr_w;
        logic [ftcg_pkg::SCR_W-1:0] scr_h;
        logic [ftcg_pkg::CFG_W-1:0] walk_x;
        logic [ftcg_pkg::CFG_W-1:0] walk_y;
        logic [ftcg_pkg::CFG_W-1:0] step_x;
        logic [ftcg_pkg::CFG_W-1:0] step_y;
        floor_px_t                  expected_q [$];
        int unsigned                mismatches;
        int unsigned                pixels;
        int unsigned                row_starts;
        int unsigned                off_rows;

        function new();
            foreach (cam[i]) cam[i] = '0;
            scr_w = ftcg_pkg::SCR_W'(640);
            scr_h = ftcg_pkg::SCR_W'(480);
            walk_x = '0;
            walk_y = '0;
            step_x = '0;
            step_y = '0;
            mismatches = 0;
            pixels = 0;
            row_starts = 0;
            off_rows = 0;
        endfunction

        function longint sx32(logic [ftcg_pkg::CFG_W-1:0] v);
            return longint'($signed(v));
        endfunction

        function logic [ftcg_pkg::CFG_W-1:0] sat32(longint v);
            if (v > longint'(32'h7fffffff)) return 32'h7fffffff;
            if (v < -longint'(32'h80000000)) return 32'h80000000;
            return v[31:0];
        endfunction

        function int unsigned clamp_res(logic [ftcg_pkg::SCR_W-1:0] v);
            return (v > ftcg_pkg::MAX_RES) ? ftcg_pkg::MAX_RES : int'(v);
        endfunction

        // Fraction truncates toward zero, so negative positions keep their sign.
        function int unsigned tex_coord(logic [ftcg_pkg::CFG_W-1:0] p);
            longint frac;
            frac = sx32(p) % 65536;
            return int'((frac * TEX_SIZE / 65536) & (TEX_SIZE - 1));
        endfunction

        function void write_reg(ftcg_pkg::cfg_reg_t idx, logic [ftcg_pkg::CFG_W-1:0] d);
            case (idx)
                ftcg_pkg::REG_SCREEN_WIDTH:  scr_w = d[ftcg_pkg::SCR_W-1:0];
                ftcg_pkg::REG_SCREEN_HEIGHT: scr_h = d[ftcg_pkg::SCR_W-1:0];
                default:                     cam[idx] = d;
            endcase
        endfunction

        function void note_pixel(logic [ftcg_pkg::ROW_W-1:0] row,
                                 logic [ftcg_pkg::ROW_W-1:0] col);
            int unsigned h;
            int unsigned w;
            longint      p;
            longint      rd;
            longint      wd;
            floor_px_t   e;
            h = clamp_res(scr_h);
            w = clamp_res(scr_w);
            pixels++;
            e.floor_row   = row;
            e.column      = col;
            e.ok          = (row > h / 2) && (row < h);
            e.texel       = '0;
            e.ceiling_row = '0;
            if (e.ok) begin
                if (col == 0) begin
                    p  = longint'(row) - longint'(h / 2);
                    rd = longint'(h) * 32768 / p;
                    wd = longint'((w == 0) ? 1 : w) * 65536;
                    step_x = sat32(2 * sx32(cam[ftcg_pkg::REG_PLANE_X]) * rd / wd);
                    step_y = sat32(2 * sx32(cam[ftcg_pkg::REG_PLANE_Y]) * rd / wd);
                    walk_x = sat32(sx32(cam[ftcg_pkg::REG_POS_X])
                                   + (sx32(cam[ftcg_pkg::REG_DIR_X])
                                      - sx32(cam[ftcg_pkg::REG_PLANE_X])) * rd / 65536);
                    walk_y = sat32(sx32(cam[ftcg_pkg::REG_POS_Y])
                                   + (sx32(cam[ftcg_pkg::REG_DIR_Y])
                                      - sx32(cam[ftcg_pkg::REG_PLANE_Y])) * rd / 65536);
                    row_starts++;
                end
                e.texel       = ftcg_pkg::TEXEL_W'(tex_coord(walk_y) * TEX_SIZE
                                                   + tex_coord(walk_x));
                e.ceiling_row = ftcg_pkg::ROW_W'(h - row - 1);
                walk_x = walk_x + step_x;
                walk_y = walk_y + step_y;
            end else begin
                off_rows++;
            end
            expected_q.push_back(e);
        endfunction

        function void check_result(floor_px_t got);
            floor_px_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: texel %0d row %0d ceil %0d col %0d ok %0b",
                             got.texel, got.floor_row, got.ceiling_row, got.column, got.ok);
                return;
            end
            want = expected_q.pop_front();
            if (got.texel !== want.texel || got.floor_row !== want.floor_row ||
                got.ceiling_row !== want.ceiling_row || got.column !== want.column ||
                got.ok !== want.ok) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected texel %0d row %0d ceil %0d col %0d ok %0b",
                             want.texel, want.floor_row, want.ceiling_row, want.column,
                             want.ok);
                    $display("          got      texel %0d row %0d ceil %0d col %0d ok %0b",
                             got.texel, got.floor_row, got.ceiling_row, got.column, got.ok);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [ftcg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ftcg_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [ftcg_pkg::ROW_W-1:0]     s_row = '0;
    logic [ftcg_pkg::ROW_W-1:0]     s_column = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [ftcg_pkg::TEXEL_W-1:0]   m_texel_index;
    logic [ftcg_pkg::ROW_W-1:0]     m_floor_row;
    logic [ftcg_pkg::ROW_W-1:0]     m_ceiling_row;
    logic [ftcg_pkg::ROW_W-1:0]     m_pixel_column;
    logic                           m_row_ok;

    floor_px_board board = new();
    int unsigned   src_idle_pct = 0;
    int unsigned   sink_idle_pct = 0;
    int unsigned   cur_h = 480;
    int unsigned   views = 0;
    logic          hung = 1'b0;

    floor_texture_coord_gen #(
        .TEX_SIZE(TEX_SIZE)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_row         (s_row),
        .s_column      (s_column),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_texel_index (m_texel_index),
        .m_floor_row   (m_floor_row),
        .m_ceiling_row (m_ceiling_row),
        .m_pixel_column(m_pixel_column),
        .m_row_ok      (m_row_ok)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Check each accepted result item, then pick the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result({m_texel_index, m_floor_row, m_ceiling_row,
                                m_pixel_column, m_row_ok});
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic write_reg(ftcg_pkg::cfg_reg_t idx, logic [ftcg_pkg::CFG_W-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(posedge aclk);
        board.write_reg(idx, d);
    endtask

    // Screen writes carry random upper bits; the block keeps only the low 12.
    task automatic apply_view(logic [ftcg_pkg::CFG_W-1:0] px, logic [ftcg_pkg::CFG_W-1:0] py,
                              logic [ftcg_pkg::CFG_W-1:0] dx, logic [ftcg_pkg::CFG_W-1:0] dy,
                              logic [ftcg_pkg::CFG_W-1:0] plx,
                              logic [ftcg_pkg::CFG_W-1:0] ply,
                              logic [ftcg_pkg::SCR_W-1:0] w, logic [ftcg_pkg::SCR_W-1:0] h);
        logic [ftcg_pkg::CFG_W-1:0] junk;
        junk = $urandom();
        write_reg(ftcg_pkg::REG_POS_X, px);
        write_reg(ftcg_pkg::REG_POS_Y, py);
        write_reg(ftcg_pkg::REG_DIR_X, dx);
        write_reg(ftcg_pkg::REG_DIR_Y, dy);
        write_reg(ftcg_pkg::REG_PLANE_X, plx);
        write_reg(ftcg_pkg::REG_PLANE_Y, ply);
        write_reg(ftcg_pkg::REG_SCREEN_WIDTH, {junk[31:12], w});
        write_reg(ftcg_pkg::REG_SCREEN_HEIGHT, {junk[19:0], h});
        cfg_wr_en <= 1'b0;
        cur_h = (h > ftcg_pkg::MAX_RES) ? ftcg_pkg::MAX_RES : h;
        views++;
    endtask

    task automatic send_pixel(int unsigned r, int unsigned c);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_row    <= ftcg_pkg::ROW_W'(r);
        s_column <= ftcg_pkg::ROW_W'(c);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_pixel(ftcg_pkg::ROW_W'(r), ftcg_pkg::ROW_W'(c));
    endtask

    // Let every outstanding item come back, plus a little slack for the pipe.
    task automatic drain();
        while (board.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Near-origin Q16.16 value, within +/-128.0.
    function automatic logic [ftcg_pkg::CFG_W-1:0] near_value();
        logic [ftcg_pkg::CFG_W-1:0] r;
        r = $urandom();
        return {{8{r[23]}}, r[23:0]};
    endfunction

    task automatic setup_view(int ph);
        case (ph)
            0: apply_view(32'h0016_8000, 32'h000b_4000, 32'hffff_0000, 32'h0000_0000,
                          32'h0000_0000, 32'h0000_a8f5, 12'd640, 12'd480);
            // Saturate start and step; narrowest screen, tallest screen.
            1: apply_view(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                          32'h7fff_ffff, 32'h8000_0000, 12'd1, 12'd2048);
            // Width zero divides by one; oversize height clamps.
            2: apply_view(near_value(), near_value(), near_value(), near_value(),
                          near_value(), near_value(), 12'd0, 12'd4095);
            3: apply_view($urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), 12'd4095, 12'd481);
            // No row fits strictly between half height and height.
            4: apply_view(near_value(), near_value(), near_value(), near_value(),
                          near_value(), near_value(), 12'd2048, 12'd2);
            default: apply_view(near_value(), near_value(), near_value(), near_value(),
                                near_value(), near_value(),
                                ftcg_pkg::SCR_W'($urandom_range(2048, 1)),
                                ftcg_pkg::SCR_W'($urandom_range(2048, 3)));
        endcase
    endtask

    // Edge rows and columns on a 640 x 480 screen.
    task automatic directed_pixels();
        int unsigned rows [18] = '{241, 241, 479, 479, 479, 240, 480, 0, 2047,
                                   2047, 300, 300, 300, 300, 300, 1023, 250, 250};
        int unsigned cols [18] = '{0, 1, 0, 1, 2, 0, 0, 0, 2047,
                                   0, 5, 0, 639, 640, 2047, 1024, 0, 1};
        foreach (rows[i]) send_pixel(rows[i], cols[i]);
    endtask

    // Mostly whole rows (start at column zero, then walk right), some noise.
    task automatic random_pixels(int unsigned n);
        int unsigned sent;
        int unsigned r;
        int unsigned len;
        int unsigned c;
        sent = 0;
        while (sent < n) begin
            if (cur_h >= 3 && $urandom_range(99) < 75) begin
                r   = $urandom_range(cur_h - 1, cur_h / 2 + 1);
                len = $urandom_range(12, 1);
                c   = ($urandom_range(9) == 0) ? $urandom_range(2047, 1) : 0;
                for (int k = 0; k < len; k++) begin
                    send_pixel(r, (c + k) % 2048);
                    sent++;
                end
            end else begin
                send_pixel($urandom_range(2047),
                           ($urandom_range(3) == 0) ? 0 : $urandom_range(2047));
                sent++;
            end
        end
    endtask

    task automatic run_all();
        int unsigned budget [6] = '{75, 90, 90, 90, 30, 160};
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 2) begin
                src_idle_pct  = 30;
                sink_idle_pct = 88;
            end else if (ph < 4) begin
                src_idle_pct  = 88;
                sink_idle_pct = 30;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            setup_view(ph);
            if (ph == 0) directed_pixels();
            random_pixels(budget[ph]);
            s_valid <= 1'b0;
            drain();
        end
    endtask

    // Give up when no handshake happens on either side for too long.
    task automatic watch_for_hang();
        int unsigned quiet;
        quiet = 0;
        while (quiet < HANG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        hung = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        fork
            run_all();
            watch_for_hang();
        join_any
        disable fork;
        if (hung) $display("timeout: no handshake for %0d cycles", HANG_LIMIT);
        $display("Ran %0d pixels over %0d camera/screen setups, %0d row starts,",
                 board.pixels, views, board.row_starts);
        $display("%0d pixels outside the floor half, %0d mismatches.",
                 board.off_rows, board.mismatches);
        if (!hung && board.mismatches == 0 && board.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
